FILE: rtl/txtcon_pkg.sv
// ----------------------------------------------------------------------------
// txtcon_pkg
// Shared types and constants of the text console writer: opcodes, register
// indexes, field widths and the default screen geometry.
// ----------------------------------------------------------------------------
package txtcon_pkg;

  // Default screen geometry.
  localparam int unsigned DefColumns = 80;
  localparam int unsigned DefRows    = 25;

  // Field widths of the stream payloads.
  localparam int unsigned OpW      = 2;
  localparam int unsigned CharW    = 8;
  localparam int unsigned RdRowW   = 5;
  localparam int unsigned RdColW   = 7;
  localparam int unsigned CurRowW  = 5;
  localparam int unsigned CurColW  = 7;
  localparam int unsigned AttrW    = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;

  typedef enum logic [OpW-1:0] {
    OpWrite = 2'd0,
    OpClear = 2'd1,
    OpRead  = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegFgColor = 1'b0,
    RegBgColor = 1'b1
  } cfg_reg_e;

  localparam logic [CharW-1:0]    BlankChar   = 8'd32;
  localparam logic [CharW-1:0]    NewlineChar = 8'd10;
  localparam logic [CfgDataW-1:0] FgReset     = 4'd7;
  localparam logic [CfgDataW-1:0] BgReset     = 4'd0;

endpackage

FILE: rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: a ROWS by COLUMNS screen of character/attribute cells
// in one memory, a cursor, and a small sequencer that writes, scrolls, clears
// and reads the screen one cell per cycle through two address counters.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields
//  s_axis    in         tuser: opcode; tdata: char_code, read_row, read_col
//  m_axis    out        tdata: cursor_row, cursor_col, cell_char, cell_attr
//  cfg       in         index 0 fg_color, index 1 bg_color
//
//  Steps per transfer: a write passes StWrite and StDone (a full-row wrap fits
//  within them), a newline goes to StDone, a read passes StRdReq, StRdWait and
//  StDone, a clear passes StBlank, and a newline on the bottom row scrolls
//  and blanks the last row, then writes the character if a write on a full
//  bottom row caused it (the scroll copies one cell a cycle through the single
//  memory port pair). After reset a clearing pass zeroes every cell of the
//  screen; s_axis_tready stays low during it.
//  A finished result sits in the output register while the next transfer is
//  taken; a stalled output holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
  parameter int unsigned COLUMNS = txtcon_pkg::DefColumns,
  parameter int unsigned ROWS    = txtcon_pkg::DefRows
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tuser: [1:0] opcode
  input  logic [txtcon_pkg::OpW-1:0]          s_axis_tuser,
  // tdata: [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [txtcon_pkg::InDataW-1:0]      s_axis_tdata,
  // Output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [4:0] cursor_row, [11:5] cursor_col, [19:12] cell_char,
  //        [27:20] cell_attr, [31:28] zero
  output logic [txtcon_pkg::OutDataW-1:0]     m_axis_tdata,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [txtcon_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [txtcon_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import txtcon_pkg::*;

  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(Cells);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLUMNS + 1);
  localparam int unsigned MulW  = AW + RdRowW;

  localparam logic [AW-1:0]   LastAddr    = AW'(Cells - 1);
  localparam logic [AW-1:0]   LastRowAddr = AW'(Cells - COLUMNS);
  localparam logic [AW-1:0]   RowStep     = AW'(COLUMNS);
  localparam logic [RowW-1:0] LastRow     = RowW'(ROWS - 1);
  localparam logic [ColW-1:0] ColFull     = ColW'(COLUMNS);

  // Sequencer states.
  localparam logic [3:0] StInit   = 4'd0;
  localparam logic [3:0] StIdle   = 4'd1;
  localparam logic [3:0] StWrite  = 4'd2;
  localparam logic [3:0] StScroll = 4'd3;
  localparam logic [3:0] StScEnd  = 4'd4;
  localparam logic [3:0] StBlank  = 4'd5;
  localparam logic [3:0] StRdReq  = 4'd6;
  localparam logic [3:0] StRdWait = 4'd7;
  localparam logic [3:0] StDone   = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic [AW-1:0]       dst_q, dst_d;
  logic                cp_valid_q, cp_valid_d;
  logic                pend_wr_q, pend_wr_d;
  logic [RowW-1:0]     cur_row_q, cur_row_d;
  logic [ColW-1:0]     cur_col_q, cur_col_d;
  logic [AW-1:0]       base_q, base_d;
  logic [CharW-1:0]    char_q, char_d;
  logic [15:0]         cell_q, cell_d;
  logic [CfgDataW-1:0] fg_q, bg_q;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic [15:0]         screen_mem_q [Cells];
  logic [15:0]         rdata_q;

  logic                in_xfer;
  logic                out_load;
  logic [AttrW-1:0]    attr;
  logic [CharW-1:0]    in_char;
  logic [RdRowW-1:0]   in_row;
  logic [RdColW-1:0]   in_col;
  logic [MulW-1:0]     rd_lin;
  logic                rd_in_range;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [15:0]         mem_wd;

  assign in_char = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[12:8];
  assign in_col  = s_axis_tdata[19:13];
  assign attr    = {bg_q, fg_q};

  assign s_axis_tready = (state_q == StIdle);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == StDone) && (!out_valid_q || m_axis_tready);

  // Linear address of a read request, and its range check.
  assign rd_lin      = MulW'(in_row) * MulW'(COLUMNS) + MulW'(in_col);
  assign rd_in_range = (int'(in_row) < ROWS) && (int'(in_col) < COLUMNS);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FgReset;
      bg_q <= BgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFgColor: fg_q <= cfg_wdata_i;
        RegBgColor: bg_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    dst_d      = dst_q;
    cp_valid_d = 1'b0;
    pend_wr_d  = pend_wr_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    base_d     = base_q;
    char_d     = char_q;
    cell_d     = cell_q;

    unique case (state_q)
      StInit: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LastAddr) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_xfer) begin
          cell_d    = '0;
          char_d    = in_char;
          pend_wr_d = 1'b0;
          unique case (op_e'(s_axis_tuser))
            OpWrite: begin
              if (in_char == NewlineChar || cur_col_q == ColFull) begin
                // Newline, either asked for or forced by a full row.
                pend_wr_d = (in_char != NewlineChar);
                cur_col_d = '0;
                if (cur_row_q != LastRow) begin
                  cur_row_d = cur_row_q + 1'b1;
                  base_d    = base_q + RowStep;
                  state_d   = pend_wr_d ? StWrite : StDone;
                end else begin
                  ptr_d   = RowStep;
                  dst_d   = '0;
                  state_d = StScroll;
                end
              end else begin
                state_d = StWrite;
              end
            end
            OpClear: begin
              ptr_d   = '0;
              state_d = StBlank;
            end
            OpRead: begin
              if (rd_in_range) begin
                ptr_d   = rd_lin[AW-1:0];
                state_d = StRdReq;
              end else begin
                state_d = StDone;
              end
            end
            default: state_d = StDone;
          endcase
        end
      end
      StWrite: begin
        cur_col_d = cur_col_q + 1'b1;
        state_d   = StDone;
      end
      StScroll: begin
        // Read one cell a row below; it is written back in the next cycle.
        cp_valid_d = 1'b1;
        ptr_d      = ptr_q + 1'b1;
        if (ptr_q == LastAddr) begin
          state_d = StScEnd;
        end
      end
      StScEnd: begin
        ptr_d   = LastRowAddr;
        state_d = StBlank;
      end
      StBlank: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LastAddr) begin
          state_d = pend_wr_q ? StWrite : StDone;
        end
      end
      StRdReq: begin
        state_d = StRdWait;
      end
      StRdWait: begin
        cell_d  = rdata_q;
        state_d = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase

    if (cp_valid_q) begin
      dst_d = dst_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StInit;
      ptr_q      <= '0;
      dst_q      <= '0;
      cp_valid_q <= 1'b0;
      pend_wr_q  <= 1'b0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      base_q     <= '0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      dst_q      <= dst_d;
      cp_valid_q <= cp_valid_d;
      pend_wr_q  <= pend_wr_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      base_q     <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    cell_q <= cell_d;
  end

  // Memory write port: scroll copies take priority over the sequencer.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q;
    mem_wd = {attr, BlankChar};
    if (cp_valid_q) begin
      mem_we = 1'b1;
      mem_wa = dst_q;
      mem_wd = rdata_q;
    end else begin
      case (state_q)
        StInit: begin
          mem_we = 1'b1;
          mem_wd = '0;
        end
        StBlank: begin
          mem_we = 1'b1;
        end
        StWrite: begin
          mem_we = 1'b1;
          mem_wa = base_q + AW'(cur_col_q);
          mem_wd = {attr, char_q};
        end
        default: ;
      endcase
    end
  end

  // Screen memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= screen_mem_q[ptr_q];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {4'b0, cell_q[15:8], cell_q[7:0],
                     CurColW'(cur_col_q), CurRowW'(cur_row_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: rtl/txtcon_checker.sv
// ----------------------------------------------------------------------------
// txtcon_checker
// Port-level checks of the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
module txtcon_checker #(
  parameter int unsigned COLUMNS = txtcon_pkg::DefColumns
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [txtcon_pkg::OutDataW-1:0] m_axis_tdata
);
  import txtcon_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Transfers taken whose result has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The block is busy in the cycle after taking a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("ready right after a transfer");

  // Never a result without a transfer, and at most two in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!m_axis_tvalid || pend_q != 2'd0))
    else $error("results and transfers out of step");

  // The reported cursor column never passes the row width (checked for COLUMNS up to 127).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (COLUMNS > 127) || (int'(m_axis_tdata[11:5]) <= COLUMNS))
    else $error("cursor column out of range");

endmodule

bind text_console_writer_core txtcon_checker #(
  .COLUMNS(COLUMNS)
) u_txtcon_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
